[hw/rtl/dbns_pkg.sv]
package dbns_pkg;

  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_WORDS_DEF = 1024;

  localparam int ID_W  = 16;
  localparam int POS_W = 17;
  localparam int ID_MAX = 65535;

  localparam logic [ID_W-1:0] DOC_COUNT_RST = 16'hFFFF;

  // request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_NEXT   = 2'd1;
  localparam logic [1:0] KIND_SEEK   = 2'd2;
  localparam logic [1:0] KIND_REWIND = 2'd3;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] doc_id;
    logic [ID_W-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] doc_value;
  } out_item_t;

  typedef struct packed {
    logic accept;    // capture request
    logic clr;       // clearing pass write
    logic rewind;
    logic div0;      // reciprocal estimate
    logic div1;      // quotient correction
    logic rd_q;      // read address from quotient, else cursor
    logic ins_wr;    // write back inserted word
    logic seek_end;  // seek target beyond words in use
    logic seek_ld;   // load target word into pending
    logic set_end;   // scan ran off the end
    logic word_ld;   // load next word into pending
    logic tz_cap;    // capture per-byte trailing-zero info
    logic take;      // consume lowest set bit, produce hit
    logic res_zero;  // produce end-of-data response
    logic out_load;  // move response into output register
  } dbns_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       at_end;
    logic       pend_nz;
    logic       cur_beyond;
    logic       q_beyond;
    logic       ins_ok;
    logic       out_free;
    logic [1:0] kind;
  } dbns_stat_t;

endpackage

[hw/rtl/dbns_ram.sv]
module dbns_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/dbns_ctrl.sv]
module dbns_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [1:0]             in_kind,
  output logic                   in_stall,
  input  dbns_pkg::dbns_stat_t   stat,
  output dbns_pkg::dbns_cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DIV0   = 4'd2;
  localparam logic [3:0] S_DIV1   = 4'd3;
  localparam logic [3:0] S_INS_RD = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_SK_CHK = 4'd6;
  localparam logic [3:0] S_SK_LD  = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_LD     = 4'd9;
  localparam logic [3:0] S_TZ     = 4'd10;
  localparam logic [3:0] S_TAKE   = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_kind) inside
            dbns_pkg::KIND_INSERT, dbns_pkg::KIND_SEEK: state_nxt = S_DIV0;
            dbns_pkg::KIND_NEXT: begin
              if (stat.at_end) begin
                cmd.res_zero = 1'b1;
                state_nxt    = S_OUT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            dbns_pkg::KIND_REWIND: cmd.rewind = 1'b1;
          endcase
        end
      end
      S_DIV0: begin
        cmd.div0  = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        cmd.div1  = 1'b1;
        state_nxt = (stat.kind == dbns_pkg::KIND_INSERT) ? S_INS_RD : S_SK_CHK;
      end
      S_INS_RD: begin
        cmd.rd_q  = 1'b1;
        state_nxt = stat.ins_ok ? S_INS_WR : S_IDLE;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SK_CHK: begin
        cmd.rd_q = 1'b1;
        if (stat.q_beyond) begin
          cmd.seek_end = 1'b1;
          cmd.res_zero = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_SK_LD;
        end
      end
      S_SK_LD: begin
        cmd.seek_ld = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        if (stat.pend_nz) begin
          state_nxt = S_TZ;
        end else if (stat.cur_beyond) begin
          cmd.set_end  = 1'b1;
          cmd.res_zero = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_LD;
        end
      end
      S_LD: begin
        cmd.word_ld = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_TZ: begin
        cmd.tz_cap = 1'b1;
        state_nxt  = S_TAKE;
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // write-back always follows its read of the same word
  a_ins_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_WR) |-> ($past(state_r) == S_INS_RD))
    else $error("insert write without preceding read");

  // trailing-zero info must be fresh when a bit is consumed
  a_take_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE) |-> ($past(state_r) == S_TZ))
    else $error("take without trailing-zero capture");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("response loaded over an unread one");
`endif

endmodule

[hw/rtl/dbns_dpath.sv]
module dbns_dpath #(
  parameter int WORD_BITS = dbns_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = dbns_pkg::MAX_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dbns_pkg::dbns_cmd_t                cmd,
  output dbns_pkg::dbns_stat_t               stat,
  input  dbns_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output dbns_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dbns_pkg::ID_W-1:0]          cfg_data
);

  localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW    = $clog2(dbns_pkg::ID_MAX / WORD_BITS + 2);
  localparam int BW    = $clog2(WORD_BITS);
  localparam int NG    = (WORD_BITS + 7) / 8;
  localparam int RECIP = (dbns_pkg::ID_MAX + 1) / WORD_BITS;
  localparam int PW    = dbns_pkg::POS_W;
  localparam int IW    = dbns_pkg::ID_W;

  function automatic logic [2:0] tz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) n = 3'(i);
    end
    return n;
  endfunction

  // registers
  logic [IW-1:0]        doc_count_r;
  logic [AW-1:0]        clr_r;
  dbns_pkg::in_item_t   item_r;
  logic [IW-1:0]        num_r;
  logic [CW-1:0]        q0_r, q_r;
  logic [BW-1:0]        r_r;
  logic [CW-1:0]        cursor_r, cursor_nxt;
  logic [WORD_BITS-1:0] pending_r, pending_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 at_end_r, at_end_nxt;
  logic [NG-1:0]        gnz_r;
  logic [2:0]           gtz_r [NG];
  dbns_pkg::out_item_t  res_r, out_r;
  logic                 out_valid_r;

  // combinational
  logic [31:0]          recip_prod;
  logic [PW-1:0]        q0_prod, r0, qprod, cprod, pos_take;
  logic [BW-1:0]        delta;
  logic [NG*8-1:0]      pend_pad;
  logic [WORD_BITS-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic                 ram_we;

  dbns_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = cmd.clr | cmd.ins_wr;
  assign ram_waddr = cmd.clr ? clr_r : AW'(q_r);
  assign ram_wdata = cmd.clr ? '0 : (ram_rdata | (WORD_BITS'(1'b1) << r_r));
  assign ram_raddr = cmd.rd_q ? AW'(q_r) : AW'(cursor_r);

  assign recip_prod = 32'(num_r) * 32'(RECIP);
  assign q0_prod    = PW'(q0_r) * PW'(WORD_BITS);
  assign r0         = PW'(num_r) - q0_prod;
  assign qprod      = PW'(q_r) * PW'(WORD_BITS);
  assign cprod      = PW'(cursor_r) * PW'(WORD_BITS);
  assign pend_pad   = (NG*8)'(pending_r);

  always_comb begin
    delta = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (gnz_r[g]) delta = BW'(g * 8) + BW'(gtz_r[g]);
    end
  end

  assign pos_take = pos_r + PW'(delta) + PW'(1);

  // status
  assign stat.clr_last   = (clr_r == AW'(MAX_WORDS - 1));
  assign stat.at_end     = at_end_r;
  assign stat.pend_nz    = |pending_r;
  assign stat.cur_beyond = (cprod > PW'(doc_count_r)) || (PW'(cursor_r) >= PW'(MAX_WORDS));
  assign stat.q_beyond   = (qprod > PW'(doc_count_r)) || (PW'(q_r) >= PW'(MAX_WORDS));
  assign stat.ins_ok     = (item_r.doc_id <= doc_count_r) && (PW'(q_r) < PW'(MAX_WORDS));
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign stat.kind       = item_r.kind;

  // scan state
  always_comb begin
    cursor_nxt  = cursor_r;
    pending_nxt = pending_r;
    pos_nxt     = pos_r;
    at_end_nxt  = at_end_r;
    if (cmd.rewind) begin
      cursor_nxt  = '0;
      pending_nxt = '0;
      pos_nxt     = '1;
      at_end_nxt  = 1'b0;
    end
    if (cmd.seek_end) begin
      cursor_nxt  = q_r;
      pending_nxt = '0;
      at_end_nxt  = 1'b1;
    end
    if (cmd.seek_ld) begin
      cursor_nxt  = q_r + CW'(1);
      pending_nxt = ram_rdata >> r_r;
      pos_nxt     = qprod - PW'(1) + PW'(r_r);
      at_end_nxt  = 1'b0;
    end
    if (cmd.set_end) begin
      at_end_nxt = 1'b1;
    end
    if (cmd.word_ld) begin
      cursor_nxt  = cursor_r + CW'(1);
      pending_nxt = ram_rdata;
      pos_nxt     = cprod - PW'(1);
    end
    if (cmd.take) begin
      pending_nxt = (pending_r >> delta) >> 1;
      pos_nxt     = pos_take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      doc_count_r <= dbns_pkg::DOC_COUNT_RST;
      clr_r       <= '0;
      cursor_r    <= '0;
      pending_r   <= '0;
      pos_r       <= '1;
      at_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        doc_count_r <= cfg_data;
      end
      if (cmd.clr) begin
        clr_r <= clr_r + AW'(1);
      end
      cursor_r  <= cursor_nxt;
      pending_r <= pending_nxt;
      pos_r     <= pos_nxt;
      at_end_r  <= at_end_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.div0) begin
      q0_r <= CW'(recip_prod >> IW);
    end
    if (cmd.accept) begin
      num_r <= (in_data.kind == dbns_pkg::KIND_SEEK) ? in_data.target : in_data.doc_id;
    end
    if (cmd.div1) begin
      // estimate is low by at most one
      if (r0 >= PW'(WORD_BITS)) begin
        q_r <= q0_r + CW'(1);
        r_r <= BW'(r0 - PW'(WORD_BITS));
      end else begin
        q_r <= q0_r;
        r_r <= BW'(r0);
      end
    end
    if (cmd.tz_cap) begin
      for (int g = 0; g < NG; g++) begin
        gnz_r[g] <= |pend_pad[g*8 +: 8];
        gtz_r[g] <= tz8(pend_pad[g*8 +: 8]);
      end
    end
    if (cmd.res_zero) begin
      res_r <= '0;
    end else if (cmd.take) begin
      res_r.found     <= 1'b1;
      res_r.doc_value <= pos_take[IW-1:0];
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    at_end_r |-> (pending_r == '0))
    else $error("pending bits left at end of data");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.found) |-> (out_r.doc_value == '0))
    else $error("end-of-data response carries an id");

  // a stalled response stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled response changed");
`endif

endmodule

[hw/rtl/doc_bitmap_next_set_scanner_unit.sv]
// Next-set-bit scanner over a bitmap of document ids.
// Input channel (in_valid / in_stall / in_data): one request per handshake.
//   insert sets the bit of doc_id (ignored above doc_count), next returns the
//   next set id after the cursor, seek returns the first set id at or after
//   target, rewind puts the cursor before id 0. insert and rewind give no
//   response; next and seek give exactly one on out_valid / out_stall / out_data.
// Config channel (cfg_valid / cfg_ready / cfg_data): doc_count, always ready.
//   Write only while the block is idle.
// Sequencing: the bitmap is one word-wide RAM with registered read, one port
//   each way; each word a scan reads passes a check and a load state. A next
//   whose current word still holds bits goes to trailing-zero capture and
//   take; seek divides for the word index and reads that word first. insert
//   divides, reads, writes back; rewind acts at once. One request at a time.
// Reset: synchronous, rst_n low. Afterwards a clearing pass zeroes the bitmap,
//   one word per cycle over all MAX_WORDS words, with in_stall held high.
// Output stall: the response sits in an output register; the block goes on
//   to accept the next request, but a further response waits until the
//   register is taken.
module doc_bitmap_next_set_scanner_unit #(
  parameter int WORD_BITS = dbns_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = dbns_pkg::MAX_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  dbns_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dbns_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dbns_pkg::ID_W-1:0] cfg_data
);

  dbns_pkg::dbns_cmd_t  cmd;
  dbns_pkg::dbns_stat_t stat;

  // sequencer: clearing pass, divide, read-modify-write, word scan
  dbns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap RAM, cursor state, trailing-zero search, response registers
  dbns_dpath #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import dbns_pkg::*;

  localparam int WBITS  = WORD_BITS_DEF;
  localparam int NWORDS = MAX_WORDS_DEF;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ID_W-1:0]   cfg_data;

  doc_bitmap_next_set_scanner_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Scanner mirror: bitmap, cursor and doc_count as the block should hold them
  // ---------------------------------------------------------------------------
  bit [WBITS-1:0]  bmap [NWORDS];
  int unsigned     cur_word  = 0;
  bit [WBITS-1:0]  pend      = '0;         // unread bits, bit 0 = id after pos
  bit [POS_W-1:0]  pos       = '1;         // all ones = before id 0
  bit              past_end  = 1'b0;
  bit [ID_W-1:0]   doc_limit = DOC_COUNT_RST;

  out_item_t       answers_due [$];        // responses still owed by the block
  int              errors     = 0;
  bit              idle_on    = 1'b1;      // random gaps / stalls enabled
  int              hold_left  = 0;         // long output hold-off, in cycles

  function automatic int unsigned words_used();
    int unsigned w;
    w = (int'(doc_limit) + WBITS) / WBITS;
    return (w > NWORDS) ? NWORDS : w;
  endfunction

  // walk to the next set id after the cursor; empty words are skipped
  function automatic out_item_t scan_forward();
    out_item_t   r;
    int unsigned tz;
    r = '0;
    if (past_end) return r;
    while (pend == '0) begin
      if (cur_word >= words_used()) begin
        past_end = 1'b1;
        return r;
      end
      pend = bmap[cur_word];
      pos  = POS_W'(cur_word * WBITS - 1);
      cur_word++;
    end
    tz = 0;
    while (tz < WBITS - 1 && pend[tz] == 1'b0) tz++;
    pend = (pend >> tz) >> 1;
    pos  = pos + POS_W'(1 + tz);
    r.found     = 1'b1;
    r.doc_value = pos[ID_W-1:0];
    return r;
  endfunction

  // apply one accepted request to the mirror, queue the response it owes
  function automatic void mirror_request(in_item_t req);
    int unsigned w, b;
    case (req.kind)
      KIND_INSERT: begin
        w = req.doc_id / WBITS;
        if (req.doc_id <= doc_limit && w < NWORDS)
          bmap[w][req.doc_id % WBITS] = 1'b1;
      end
      KIND_NEXT: answers_due.push_back(scan_forward());
      KIND_SEEK: begin
        w = req.target / WBITS;
        b = req.target % WBITS;
        past_end = 1'b0;
        if (w >= words_used()) begin
          // seek past the data: cursor parks on that word, end of data
          cur_word = w;
          pend     = '0;
          past_end = 1'b1;
          answers_due.push_back('0);
        end else begin
          pend     = bmap[w] >> b;
          pos      = POS_W'(w * WBITS - 1 + b);
          cur_word = w + 1;
          answers_due.push_back(scan_forward());
        end
      end
      default: begin
        cur_word = 0;
        pend     = '0;
        pos      = '1;
        past_end = 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // worst case is every next scanning all 1024 words
  initial begin
    #200_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Response side: stall bursts and the long hold-off, driven on falling edges
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int burst;
    burst     = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        burst     = $urandom_range(1, 7) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // compare every taken response with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $error("response with none outstanding: found %0d doc_value %0d",
               out_data.found, out_data.doc_value);
        errors++;
      end else begin
        if (out_data.found !== answers_due[0].found) begin
          $error("found: expected %0d, actual %0d",
                 answers_due[0].found, out_data.found);
          errors++;
        end
        if (out_data.doc_value !== answers_due[0].doc_value) begin
          $error("doc_value: expected %0d, actual %0d",
                 answers_due[0].doc_value, out_data.doc_value);
          errors++;
        end
        void'(answers_due.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // value lands in doc_id for insert, target for seek; unused fields random
  function automatic in_item_t make_request(logic [1:0] kind, logic [ID_W-1:0] value);
    in_item_t r;
    r.kind   = kind;
    r.doc_id = ID_W'($urandom);
    r.target = ID_W'($urandom);
    if (kind == KIND_INSERT) r.doc_id = value;
    if (kind == KIND_SEEK)   r.target = value;
    return r;
  endfunction

  // valid is left high on return; the next caller either reuses it or drops it
  task automatic send_request(input in_item_t req);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap      = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    do @(posedge clk); while (in_stall);
    mirror_request(req);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // wait out every owed response, then the tail of an insert still in flight
  task automatic drain();
    drop_valid();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (32) @(negedge clk);
  endtask

  task automatic write_doc_count(input logic [ID_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    doc_limit = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random request, mostly in range of the ids in use
  function automatic in_item_t random_request();
    int unsigned     r;
    logic [ID_W-1:0] v;
    r = $urandom_range(0, 99);
    v = ($urandom_range(0, 3) == 0) ? ID_W'($urandom)
                                    : ID_W'($urandom_range(0, doc_limit));
    if (r < 40)      return make_request(KIND_INSERT, v);
    else if (r < 75) return make_request(KIND_NEXT, v);
    else if (r < 90) return make_request(KIND_SEEK, v);
    else             return make_request(KIND_REWIND, v);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // empty bitmap, extremes of id and target, cursor walking across words,
  // an insert into a word already taken, seek backward and rewind
  task automatic test_directed_walk();
    send_request(make_request(KIND_NEXT, '0));      // empty: full scan, end
    send_request(make_request(KIND_NEXT, '0));      // stays at end
    send_request(make_request(KIND_REWIND, '0));
    send_request(make_request(KIND_INSERT, 16'd0));
    send_request(make_request(KIND_INSERT, 16'd63));
    send_request(make_request(KIND_INSERT, 16'd64));
    send_request(make_request(KIND_INSERT, 16'hFFFF));
    send_request(make_request(KIND_INSERT, 16'h5555));
    send_request(make_request(KIND_INSERT, 16'hAAAA));
    repeat (3) send_request(make_request(KIND_NEXT, '0));
    send_request(make_request(KIND_INSERT, 16'd65)); // word 1 already pending
    repeat (4) send_request(make_request(KIND_NEXT, '0));
    send_request(make_request(KIND_SEEK, 16'hFFFF));
    send_request(make_request(KIND_SEEK, 16'd0));    // backward
    send_request(make_request(KIND_SEEK, 16'd65));
    send_request(make_request(KIND_REWIND, '0));
    send_request(make_request(KIND_NEXT, '0));
    send_request(make_request(KIND_SEEK, 16'hFFC0));
  endtask

  // doc_count at its minimum: old bits in word 0 stay visible, ids above are
  // dropped, seek beyond the single word in use ends the data
  task automatic test_doc_count_shrink();
    write_doc_count(16'd0);
    send_request(make_request(KIND_SEEK, 16'd0));
    repeat (2) send_request(make_request(KIND_NEXT, '0));
    send_request(make_request(KIND_SEEK, 16'd64));
    send_request(make_request(KIND_NEXT, '0));
    send_request(make_request(KIND_INSERT, 16'd1));
    send_request(make_request(KIND_INSERT, 16'hFFFF));
    send_request(make_request(KIND_REWIND, '0));
    send_request(make_request(KIND_NEXT, '0));
  endtask

  task automatic random_phase(input logic [ID_W-1:0] limit, input int count,
                              input bit idle);
    in_item_t req;
    int       n;
    write_doc_count(limit);
    idle_on = idle;
    n = 0;
    while (n < count) begin
      req = random_request();
      send_request(req);
      // ignored inserts do not count toward the phase
      if (!(req.kind == KIND_INSERT && req.doc_id > doc_limit)) n++;
    end
  endtask

  task automatic test_random_mix();
    random_phase(16'd63,    200, 1'b1);
    random_phase(16'd64,    200, 1'b1);
    random_phase(16'hFFFF,  220, 1'b1);
    random_phase(16'd1000,  200, $urandom_range(0, 1));
    random_phase(ID_W'($urandom), 200, 1'b1);
    random_phase(16'd4095,  200, $urandom_range(0, 1));
    random_phase(16'd0,     150, 1'b1);
  endtask

  // receiver holds off long enough for the block to back up into in_stall
  task automatic test_output_backpressure();
    drain();
    idle_on   = 1'b0;
    hold_left = 300;
    repeat (30)
      send_request(make_request($urandom_range(0, 1) ? KIND_NEXT : KIND_SEEK,
                                ID_W'($urandom_range(0, doc_limit))));
    idle_on = 1'b1;
  endtask

  // closing stretch at full doc_count with no gaps on either side
  task automatic test_final_streaming();
    random_phase(16'hFFFF, 250, 1'b0);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_directed_walk();
    test_doc_count_shrink();
    test_random_mix();
    test_output_backpressure();
    test_final_streaming();

    drain();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
